/* rtl/core/fts_pkg.sv */
// Shared types, constants and helpers for the flow timing statistics block.
`timescale 1ns / 1ps
package fts_pkg;

	localparam int TIME_BITS_DEF  = 64;
	localparam int COUNT_BITS_DEF = 32;
	localparam int SUM_BITS       = 64;
	localparam int SQ_BITS        = 128;
	localparam int STEP_BITS      = 8;
	localparam int OUT_BITS       = 32 + 9 * SUM_BITS;
	localparam logic [SUM_BITS-1:0] THRESH_RESET = 64'd1000000000;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ,
		OP_CLOSE,
		OP_MUL,
		OP_DIFF,
		OP_ROOT,
		OP_DIVGO,
		OP_DIVSTORE,
		OP_EMIT
	} op_t;

	// Which quotient the shared divider is working on
	typedef enum logic [1:0] {
		DIV_MEAN,
		DIV_ACTIVE,
		DIV_IDLE,
		DIV_DEV
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_CLOSE,
		ST_MUL,
		ST_DIFF,
		ST_ROOT,
		ST_DIVGO,
		ST_DIVRUN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t                  op;
		logic [STEP_BITS-1:0] step;
		div_sel_t             sel;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
		logic out_busy;
	} sts_t;

	// Period tally: count, sum and longest length
	typedef struct packed {
		logic [SUM_BITS-1:0] cnt;
		logic [SUM_BITS-1:0] sum;
		logic [SUM_BITS-1:0] max;
	} tally_t;

	function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] a,
			logic [SUM_BITS-1:0] b);
		logic [SUM_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
	endfunction

	// Record a finished period; zero-length periods are dropped
	function automatic tally_t tally_close(tally_t t, logic [SUM_BITS-1:0] len);
		tally_t r;
		r = t;
		if (len != '0) begin
			r.cnt = sat_add(t.cnt, {{(SUM_BITS-1){1'b0}}, 1'b1});
			r.sum = sat_add(t.sum, len);
			if (len > t.max) begin
				r.max = len;
			end
		end
		return r;
	endfunction

endpackage

/* rtl/core/fts_divider.sv */
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fts_divider #(
	parameter int NUM_BITS = 80,
	parameter int DEN_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [NUM_BITS-1:0] quo
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   shifted;
	logic [DEN_BITS:0]   diff;
	logic                fits;

	// trial subtract of the divisor
	always_comb begin
		shifted = {rem_q, quo_q[NUM_BITS-1]};
		diff    = shifted - {1'b0, den_q};
		fits    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_BITS'(NUM_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/core/fts_datapath.sv */
// Flow statistics datapath: accumulators, square and root steps, result register.
`timescale 1ns / 1ps
module fts_datapath #(
	parameter int TIME_BITS  = fts_pkg::TIME_BITS_DEF,
	parameter int COUNT_BITS = fts_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fts_pkg::cmd_t                  cmd,
	output fts_pkg::sts_t                  sts,
	input  logic [63:0]                    s_tdata,
	input  logic                           s_tlast,
	input  logic                           cfg_wen,
	input  logic [63:0]                    cfg_wdata,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [fts_pkg::OUT_BITS-1:0]   m_tdata
);
	import fts_pkg::*;

	localparam int DW = COUNT_BITS + SQ_BITS;
	localparam int RW = (DW + 1) / 2;

	logic [SUM_BITS-1:0]   thresh_q;
	logic [TIME_BITS-1:0]  prev_q;
	logic                  have_prev_q;
	logic [TIME_BITS-1:0]  gap_q;
	logic                  gap_ok_q;
	logic                  last_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [TIME_BITS-1:0]  least_q;
	logic [TIME_BITS-1:0]  greatest_q;
	logic                  in_act_q;
	logic [SUM_BITS-1:0]   run_act_q;
	logic [SUM_BITS-1:0]   run_idle_q;
	tally_t                act_q;
	tally_t                idle_q;
	logic [DW-1:0]         nq_q;
	logic [SQ_BITS-1:0]    ss_q;
	logic [2*RW-1:0]       d_q;
	logic [RW:0]           rrem_q;
	logic [RW-1:0]         root_q;
	logic [SUM_BITS-1:0]   mean_q;
	logic [SUM_BITS-1:0]   act_mean_q;
	logic [SUM_BITS-1:0]   idle_mean_q;
	logic [SUM_BITS-1:0]   dev_q;
	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_q;

	logic [TIME_BITS-1:0]  ts;
	logic [SUM_BITS-1:0]   gap64;
	logic [31:0]           mul_a;
	logic [31:0]           mul_b;
	logic [63:0]           prod;
	logic [SQ_BITS:0]      sq_sum;
	logic [DW:0]           nq_diff;
	logic [RW+2:0]         rem_sh;
	logic [RW+2:0]         trial;
	logic [SUM_BITS-1:0]   cnt64;
	logic [RW-1:0]         div_num;
	logic [SUM_BITS-1:0]   div_den;
	logic                  div_done;
	logic [RW-1:0]         div_quo;
	logic [31:0]           cnt32;

	assign ts    = s_tdata[TIME_BITS-1:0];
	assign gap64 = SUM_BITS'(gap_q);
	assign cnt64 = SUM_BITS'(cnt_q);
	assign cnt32 = 32'(cnt_q);

	// Shared 32x32 multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = cmd.step[0] ? gap64[63:32] : gap64[31:0];
				mul_b = cmd.step[1] ? gap64[63:32] : gap64[31:0];
			end
			OP_MUL: begin
				if (!cmd.step[2]) begin
					mul_a = cnt32;
					mul_b = sq_q[32*cmd.step[1:0] +: 32];
				end else begin
					mul_a = cmd.step[0] ? sum_q[63:32] : sum_q[31:0];
					mul_b = cmd.step[1] ? sum_q[63:32] : sum_q[31:0];
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = mul_a * mul_b;
	end

	// Partial square into the saturating sum of squares; n*Q minus S^2 difference
	always_comb begin
		sq_sum = {1'b0, sq_q}
			+ ((SQ_BITS+1)'(prod) << (32 * (int'(cmd.step[0]) + int'(cmd.step[1]))));
		nq_diff = {1'b0, nq_q} - (DW+1)'(ss_q);
	end

	// One step of the digit-by-digit square root
	always_comb begin
		rem_sh = {rrem_q, d_q[2*RW-1 -: 2]};
		trial  = (RW+3)'({root_q, 2'b01});
	end

	// Divider operand select
	always_comb begin
		case (cmd.sel)
			DIV_MEAN: begin
				div_num = RW'(sum_q);
				div_den = cnt64;
			end
			DIV_ACTIVE: begin
				div_num = RW'(act_q.sum);
				div_den = act_q.cnt;
			end
			DIV_IDLE: begin
				div_num = RW'(idle_q.sum);
				div_den = idle_q.cnt;
			end
			default: begin
				div_num = root_q;
				div_den = cnt64;
			end
		endcase
	end

	fts_divider #(
		.NUM_BITS(RW),
		.DEN_BITS(SUM_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.op == OP_DIVGO),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_wen) begin
			thresh_q <= cfg_wdata;
		end
	end

	// Per-flow state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			gap_q       <= '0;
			gap_ok_q    <= 1'b0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			least_q     <= '1;
			greatest_q  <= '0;
			in_act_q    <= 1'b0;
			run_act_q   <= '0;
			run_idle_q  <= '0;
			act_q       <= '0;
			idle_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					gap_q       <= ts - prev_q;
					gap_ok_q    <= have_prev_q && (ts >= prev_q);
					prev_q      <= ts;
					have_prev_q <= 1'b1;
					last_q      <= s_tlast;
				end
				OP_SQ: begin
					if (gap_ok_q) begin
						sq_q <= sq_sum[SQ_BITS] ? '1 : sq_sum[SQ_BITS-1:0];
					end
					if (gap_ok_q && cmd.step == '0) begin
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + 1'b1;
						end
						sum_q <= sat_add(sum_q, gap64);
						if (gap_q < least_q) begin
							least_q <= gap_q;
						end
						if (gap_q > greatest_q) begin
							greatest_q <= gap_q;
						end
						if (gap64 < thresh_q) begin
							if (in_act_q) begin
								run_act_q <= sat_add(run_act_q, gap64);
							end else begin
								idle_q     <= tally_close(idle_q, run_idle_q);
								run_idle_q <= '0;
								run_act_q  <= gap64;
								in_act_q   <= 1'b1;
							end
						end else begin
							if (!in_act_q) begin
								run_idle_q <= sat_add(run_idle_q, gap64);
							end else begin
								act_q      <= tally_close(act_q, run_act_q);
								run_act_q  <= '0;
								run_idle_q <= gap64;
								in_act_q   <= 1'b0;
							end
						end
					end
				end
				OP_CLOSE: begin
					act_q  <= tally_close(act_q, run_act_q);
					idle_q <= tally_close(idle_q, run_idle_q);
				end
				OP_EMIT: begin
					out_valid_q <= 1'b1;
					prev_q      <= '0;
					have_prev_q <= 1'b0;
					gap_ok_q    <= 1'b0;
					last_q      <= 1'b0;
					cnt_q       <= '0;
					sum_q       <= '0;
					sq_q        <= '0;
					least_q     <= '1;
					greatest_q  <= '0;
					in_act_q    <= 1'b0;
					run_act_q   <= '0;
					run_idle_q  <= '0;
					act_q       <= '0;
					idle_q      <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// End-of-flow arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CLOSE: begin
				nq_q <= '0;
				ss_q <= '0;
			end
			OP_MUL: begin
				if (!cmd.step[2]) begin
					nq_q <= nq_q + (DW'(prod) << (32 * int'(cmd.step[1:0])));
				end else begin
					ss_q <= ss_q + (SQ_BITS'(prod)
						<< (32 * (int'(cmd.step[0]) + int'(cmd.step[1]))));
				end
			end
			OP_DIFF: begin
				d_q    <= nq_diff[DW] ? '0 : (2*RW)'(nq_diff[DW-1:0]);
				rrem_q <= '0;
				root_q <= '0;
			end
			OP_ROOT: begin
				d_q <= {d_q[2*RW-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rrem_q <= (RW+1)'(rem_sh - trial);
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rrem_q <= (RW+1)'(rem_sh);
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			OP_DIVSTORE: begin
				case (cmd.sel)
					DIV_MEAN:   mean_q <= (cnt_q == '0) ? '0 : div_quo[SUM_BITS-1:0];
					DIV_ACTIVE: act_mean_q <= (act_q.cnt == '0) ? '0 : div_quo[SUM_BITS-1:0];
					DIV_IDLE:   idle_mean_q <= (idle_q.cnt == '0) ? '0 : div_quo[SUM_BITS-1:0];
					default: begin
						if (cnt_q < COUNT_BITS'(2)) begin
							dev_q <= '0;
						end else if (div_quo[RW-1:SUM_BITS] != '0) begin
							dev_q <= '1;
						end else begin
							dev_q <= div_quo[SUM_BITS-1:0];
						end
					end
				endcase
			end
			OP_EMIT: begin
				out_q <= {
					idle_q.max,
					idle_mean_q,
					act_q.max,
					act_mean_q,
					(cnt_q != '0) ? SUM_BITS'(greatest_q) : {SUM_BITS{1'b0}},
					(cnt_q != '0) ? SUM_BITS'(least_q) : {SUM_BITS{1'b0}},
					dev_q,
					mean_q,
					sum_q,
					cnt32
				};
			end
			default: begin
			end
		endcase
	end

	assign sts.last     = last_q;
	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid_q;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_q;

endmodule

/* rtl/core/fts_controller.sv */
// Sequencer for per-packet updates and the end-of-flow computation.
`timescale 1ns / 1ps
module fts_controller #(
	parameter int COUNT_BITS = fts_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  fts_pkg::sts_t sts,
	output fts_pkg::cmd_t cmd
);
	import fts_pkg::*;

	localparam int RW = (COUNT_BITS + SQ_BITS + 1) / 2;
	localparam logic [STEP_BITS-1:0] ROOT_LAST = STEP_BITS'(RW - 1);
	localparam logic [STEP_BITS-1:0] SQ_LAST   = STEP_BITS'(3);
	localparam logic [STEP_BITS-1:0] MUL_LAST  = STEP_BITS'(7);

	state_t               state_q, state_d;
	logic [STEP_BITS-1:0] step_q, step_d;
	div_sel_t             sel_q, sel_d;

	// State, step and divider index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			sel_q   <= DIV_MEAN;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sel_q   <= sel_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		sel_d    = sel_q;
		s_tready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.step = step_q;
		cmd.sel  = sel_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					step_d  = '0;
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				step_d = step_q + 1'b1;
				if (step_q == SQ_LAST) begin
					step_d  = '0;
					state_d = sts.last ? ST_CLOSE : ST_IDLE;
				end
			end
			ST_CLOSE: begin
				cmd.op  = OP_CLOSE;
				step_d  = '0;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.op = OP_MUL;
				step_d = step_q + 1'b1;
				if (step_q == MUL_LAST) begin
					step_d  = '0;
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				step_d  = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.op = OP_ROOT;
				step_d = step_q + 1'b1;
				if (step_q == ROOT_LAST) begin
					step_d  = '0;
					sel_d   = DIV_MEAN;
					state_d = ST_DIVGO;
				end
			end
			ST_DIVGO: begin
				cmd.op  = OP_DIVGO;
				state_d = ST_DIVRUN;
			end
			ST_DIVRUN: begin
				if (sts.div_done) begin
					cmd.op = OP_DIVSTORE;
					if (sel_q == DIV_DEV) begin
						state_d = ST_EMIT;
					end else begin
						sel_d   = div_sel_t'(sel_q + 1'b1);
						state_d = ST_DIVGO;
					end
				end
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/flow_timing_statistics.sv */
// Top level: per-flow inter-arrival gap statistics.
// Each timestamp request takes an accept step, then four
// 32x32 partial products of the gap square on the shared multiplier.
// A flow end adds a close step, eight multiply steps, a difference step, R root steps
// (R = (COUNT_BITS+129)/2, 80 by default), four divisions, and the output load.
// The result sits in an output register; the next flow is accepted meanwhile.
// Reset clears all flow state and loads the threshold with 1e9; no clearing pass.
`timescale 1ns / 1ps
module flow_timing_statistics #(
	parameter int TIME_BITS  = fts_pkg::TIME_BITS_DEF,
	parameter int COUNT_BITS = fts_pkg::COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [63:0]                  s_tdata,  // timestamp
	input  logic                         s_tlast,  // flow_end
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// gap_count, gap_total, gap_mean, gap_deviation, gap_least, gap_greatest,
	// active_avg, active_greatest, idle_avg, idle_greatest
	output logic [fts_pkg::OUT_BITS-1:0] m_tdata,
	input  logic                         cfg_wen,
	input  logic [63:0]                  cfg_wdata  // active_threshold
);
	import fts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fts_controller #(
		.COUNT_BITS(COUNT_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fts_datapath #(
		.TIME_BITS (TIME_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule
